// ===== rtl/core/assert_macros.svh =====
// assert_macros.svh: assertion helpers for the JSON string decoder RTL.
// No dependencies. Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/jsd_pkg.sv =====
// jsd_pkg: types, codes and helpers shared by the JSON string decoder.
// No dependencies.
`timescale 1ns / 1ps

package jsd_pkg;

  // Parser modes
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_HEX
  } mode_t;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
  localparam logic [2:0] ERR_EOF      = 3'd2;
  localparam logic [2:0] ERR_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_HEX      = 3'd4;

  // ASCII characters the parser looks for
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // Control bytes produced by escapes
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0c;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_CR  = 8'h0d;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // UTF-8 encoding
  localparam logic [15:0] CP_MAX_1B  = 16'h007f;
  localparam logic [15:0] CP_MAX_2B  = 16'h07ff;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'he0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;

  // Command from parser to output side
  typedef enum logic {
    CMD_BYTE,   // one result: data[7:0], kind, err
    CMD_CP      // code point in data, sent as 1 to 3 UTF-8 bytes
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [15:0] data;
    logic [1:0]  kind;
    logic [2:0]  err;
  } cmd_t;

  // Queue write side
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  // Queue status and head entry
  typedef struct packed {
    logic empty;
    logic full;
    cmd_t head;
  } q_rd_t;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] res;
    res = '0;
    case (b) inside
      [CH_0:CH_9]:   res = {1'b1, 4'(b - CH_0)};
      [CH_LA:CH_LF]: res = {1'b1, 4'(b - CH_LA + 8'd10)};
      [CH_UA:CH_UF]: res = {1'b1, 4'(b - CH_UA + 8'd10)};
      default:       res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/jsd_in_if.sv =====
// jsd_in_if: input byte channel of the JSON string decoder.
// No dependencies.
`timescale 1ns / 1ps

interface jsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_eof;

  modport source (output valid, output in_byte, output in_eof, input ready);
  modport sink   (input valid, input in_byte, input in_eof, output ready);
endinterface

// ===== rtl/core/jsd_out_if.sv =====
// jsd_out_if: result channel of the JSON string decoder.
// No dependencies.
`timescale 1ns / 1ps

interface jsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [2:0] err_code;
  logic       last;

  modport source (output valid, output out_byte, output out_kind, output err_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input out_kind, input err_code,
                  input last, output ready);
endinterface

// ===== rtl/core/jsd_front.sv =====
// jsd_front: string parser; takes one input byte per transfer and queues
// at most one command for it. Depends on jsd_pkg and jsd_in_if.
`timescale 1ns / 1ps

module jsd_front (
  input  logic           clk,
  input  logic           rst_n,
  jsd_in_if.sink         in_ch,
  input  logic           q_full,
  output jsd_pkg::q_wr_t q_wr
);
  import jsd_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic        accept;
  logic [4:0]  hx;
  logic [15:0] cp_shift;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign hx          = hex_digit(in_ch.in_byte);
  assign cp_shift    = {cp_r[11:0], hx[3:0]};

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hex_cnt_r <= '0;
      cp_r      <= '0;
    end else begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_r      <= cp_nxt;
    end
  end

  // Next state and command
  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    cp_nxt      = cp_r;
    q_wr.push   = 1'b0;
    q_wr.cmd    = '{op: CMD_BYTE, data: '0, kind: KIND_DATA, err: ERR_NONE};
    if (accept) begin
      case (mode_r)
        MODE_IDLE: begin
          if (!in_ch.in_eof) begin
            if (in_ch.in_byte == CH_QUOTE) begin
              mode_nxt = MODE_STR;
            end else begin
              q_wr.push     = 1'b1;
              q_wr.cmd.kind = KIND_ERR;
              q_wr.cmd.err  = ERR_NO_QUOTE;
            end
          end
        end
        MODE_STR: begin
          if (in_ch.in_eof) begin
            mode_nxt      = MODE_IDLE;
            q_wr.push     = 1'b1;
            q_wr.cmd.kind = KIND_ERR;
            q_wr.cmd.err  = ERR_EOF;
          end else if (in_ch.in_byte == CH_QUOTE) begin
            mode_nxt      = MODE_IDLE;
            q_wr.push     = 1'b1;
            q_wr.cmd.kind = KIND_END;
          end else if (in_ch.in_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            q_wr.push     = 1'b1;
            q_wr.cmd.data = {8'd0, in_ch.in_byte};
          end
        end
        MODE_ESC: begin
          q_wr.push = 1'b1;
          mode_nxt  = MODE_STR;
          if (in_ch.in_eof) begin
            mode_nxt      = MODE_IDLE;
            q_wr.cmd.kind = KIND_ERR;
            q_wr.cmd.err  = ERR_EOF;
          end else begin
            case (in_ch.in_byte)
              CH_QUOTE, CH_BSLASH, CH_SLASH: q_wr.cmd.data = {8'd0, in_ch.in_byte};
              CH_B: q_wr.cmd.data = {8'd0, BYTE_BS};
              CH_F: q_wr.cmd.data = {8'd0, BYTE_FF};
              CH_N: q_wr.cmd.data = {8'd0, BYTE_LF};
              CH_R: q_wr.cmd.data = {8'd0, BYTE_CR};
              CH_T: q_wr.cmd.data = {8'd0, BYTE_TAB};
              CH_U: begin
                // start of a \u escape: no result yet
                q_wr.push   = 1'b0;
                mode_nxt    = MODE_HEX;
                hex_cnt_nxt = '0;
                cp_nxt      = '0;
              end
              default: begin
                mode_nxt      = MODE_IDLE;
                q_wr.cmd.kind = KIND_ERR;
                q_wr.cmd.err  = ERR_ESCAPE;
              end
            endcase
          end
        end
        MODE_HEX: begin
          if (in_ch.in_eof || !hx[4]) begin
            mode_nxt      = MODE_IDLE;
            hex_cnt_nxt   = '0;
            cp_nxt        = '0;
            q_wr.push     = 1'b1;
            q_wr.cmd.kind = KIND_ERR;
            q_wr.cmd.err  = in_ch.in_eof ? ERR_EOF : ERR_HEX;
          end else if (hex_cnt_r == 2'd3) begin
            // fourth digit completes the code point
            mode_nxt      = MODE_STR;
            hex_cnt_nxt   = '0;
            cp_nxt        = '0;
            q_wr.push     = 1'b1;
            q_wr.cmd.op   = CMD_CP;
            q_wr.cmd.data = cp_shift;
          end else begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
            cp_nxt      = cp_shift;
          end
        end
        default: mode_nxt = MODE_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/jsd_queue.sv =====
// jsd_queue: small command FIFO between parser and output side.
// Depends on jsd_pkg.
`timescale 1ns / 1ps

module jsd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  jsd_pkg::q_wr_t q_wr,
  input  logic           pop,
  output jsd_pkg::q_rd_t q_rd
);
  import jsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_ok, pop_ok;

  assign q_rd.empty = (count_r == '0);
  assign q_rd.full  = (count_r == CNT_W'(DEPTH));
  assign q_rd.head  = entries_r[rd_ptr_r];
  assign push_ok    = q_wr.push && !q_rd.full;
  assign pop_ok     = pop && !q_rd.empty;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push_ok, pop_ok})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/jsd_back.sv =====
// jsd_back: expands queued commands into result transfers, UTF-8 encoding
// code points into 1 to 3 bytes. Depends on jsd_pkg and jsd_out_if.
`timescale 1ns / 1ps

module jsd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  jsd_pkg::q_rd_t q_rd,
  output logic           pop,
  jsd_out_if.source      out_ch
);
  import jsd_pkg::*;

  logic [1:0]  idx_r;
  logic [1:0]  n_bytes;
  logic [7:0]  byte_sel;
  logic [15:0] cp;
  logic        is_last;
  logic        load;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [1:0]  out_kind_r;
  logic [2:0]  err_code_r;
  logic        last_r;

  assign cp = q_rd.head.data;

  // Byte count and byte at the current index
  always_comb begin
    n_bytes  = 2'd1;
    byte_sel = cp[7:0];
    if (q_rd.head.op == CMD_CP) begin
      if (cp <= CP_MAX_1B) begin
        n_bytes  = 2'd1;
        byte_sel = cp[7:0];
      end else if (cp <= CP_MAX_2B) begin
        n_bytes  = 2'd2;
        byte_sel = (idx_r == 2'd0) ? (UTF8_LEAD2 | {3'd0, cp[10:6]})
                                   : (UTF8_CONT | {2'd0, cp[5:0]});
      end else begin
        n_bytes = 2'd3;
        case (idx_r)
          2'd0:    byte_sel = UTF8_LEAD3 | {4'd0, cp[15:12]};
          2'd1:    byte_sel = UTF8_CONT | {2'd0, cp[11:6]};
          default: byte_sel = UTF8_CONT | {2'd0, cp[5:0]};
        endcase
      end
    end
  end

  assign is_last = (idx_r == n_bytes - 2'd1);
  assign load    = !q_rd.empty && (!out_valid_r || out_ch.ready);
  assign pop     = load && is_last;

  // Byte index within the current command and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_sel;
      out_kind_r <= q_rd.head.kind;
      err_code_r <= q_rd.head.err;
      last_r     <= is_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_kind = out_kind_r;
  assign out_ch.err_code = err_code_r;
  assign out_ch.last     = last_r;

endmodule

// ===== rtl/core/json_string_literal_decoder.sv =====
// json_string_literal_decoder: top level of the JSON string decoder.
// Depends on jsd_pkg, jsd_in_if, jsd_out_if, jsd_front, jsd_queue, jsd_back
// and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Decodes quoted JSON string literals one input byte per transfer, with
// escape and \u handling (code points sent as 1 to 3 UTF-8 bytes), and
// reports string ends and errors as results; the last result of each
// input byte carries last. An input byte is taken every cycle as long as
// the command queue (QUEUE_DEPTH entries) has room. The output side sends
// one result per cycle while the receiver is ready, so a \u escape
// that yields 2 or 3 bytes holds the output until its last byte is
// sent; input keeps flowing into the queue meanwhile and stalls only
// when it fills. Results pass through the queue to a registered output.
module json_string_literal_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  jsd_in_if.sink    in_ch,
  jsd_out_if.source out_ch
);
  import jsd_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_pop;

  jsd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_rd.full),
    .q_wr   (q_wr)
  );

  jsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .q_rd  (q_rd)
  );

  jsd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  // Parser never pushes into a full queue
  `ASSERT_IMPLIES(a_no_push_full, q_wr.push, !q_rd.full, "push into full command queue")
  // End of string and errors are always a single, final result
  `ASSERT_IMPLIES(a_ctrl_last, out_ch.valid && (out_ch.out_kind != KIND_DATA), out_ch.last, "end or error result not marked last")
  // Error code present exactly on error results
  `ASSERT_IMPLIES(a_err_kind, out_ch.valid, (out_ch.out_kind == KIND_ERR) == (out_ch.err_code != ERR_NONE), "error code does not match result kind")
  // A popped command leaves the queue with room
  `ASSERT_NEXT(a_pop_room, q_pop && !q_wr.push, !q_rd.full, "queue still full after pop")

endmodule

// ===== tb/json_string_literal_decoder_test.sv =====
// json_string_literal_decoder_test: self-checking bench for the JSON string decoder.
// Drives quoted strings, escapes, \u sequences and broken input over jsd_in_if and
// checks every result on jsd_out_if against a local decoder; needs jsd_pkg and the RTL.
`timescale 1ns / 1ps

module json_string_literal_decoder_test;
  import jsd_pkg::*;

  // One result as the block reports it
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] err;
    logic       last;
  } decoded_t;

  // Decoder state mirror plus the queue of results it has produced so far
  class unescape_tracker;
    mode_t       mode;
    logic [1:0]  hex_cnt;
    logic [15:0] cp;
    decoded_t    decoded_q[$];
    int          bad;
    int          n_checked;
    int          n_ends;
    int          n_errs;

    function new();
      mode      = MODE_IDLE;
      hex_cnt   = '0;
      cp        = '0;
      bad       = 0;
      n_checked = 0;
      n_ends    = 0;
      n_errs    = 0;
    endfunction

    // {is_hex, value}
    function logic [4:0] nibble_of(logic [7:0] b);
      if (b >= CH_0 && b <= CH_9) return {1'b1, 4'(b - CH_0)};
      if (b >= CH_LA && b <= CH_LF) return {1'b1, 4'(b - CH_LA + 8'd10)};
      if (b >= CH_UA && b <= CH_UF) return {1'b1, 4'(b - CH_UA + 8'd10)};
      return 5'd0;
    endfunction

    function void add(logic [7:0] d, logic [1:0] k, logic [2:0] e);
      decoded_t r;
      r.data = d;
      r.kind = k;
      r.err  = e;
      r.last = 1'b0;
      decoded_q = {decoded_q, r};
    endfunction

    // Any error drops back to idle
    function void fail(logic [2:0] e);
      mode    = MODE_IDLE;
      hex_cnt = '0;
      cp      = '0;
      add(8'h00, KIND_ERR, e);
    endfunction

    // Advance the mirror by one accepted input transfer
    function void take_text_byte(logic [7:0] b, logic eof);
      int          n0;
      logic [4:0]  d;
      logic [15:0] v;
      logic [7:0]  r;
      n0 = decoded_q.size();
      r  = b;
      case (mode)
        MODE_IDLE: begin
          if (!eof) begin
            if (b == CH_QUOTE) mode = MODE_STR;
            else fail(ERR_NO_QUOTE);
          end
        end
        MODE_STR: begin
          if (eof) fail(ERR_EOF);
          else if (b == CH_QUOTE) begin
            mode = MODE_IDLE;
            add(8'h00, KIND_END, ERR_NONE);
          end else if (b == CH_BSLASH) mode = MODE_ESC;
          else add(b, KIND_DATA, ERR_NONE);
        end
        MODE_ESC: begin
          if (eof) fail(ERR_EOF);
          else begin
            case (b)
              CH_QUOTE, CH_BSLASH, CH_SLASH: r = b;
              CH_B: r = BYTE_BS;
              CH_F: r = BYTE_FF;
              CH_N: r = BYTE_LF;
              CH_R: r = BYTE_CR;
              CH_T: r = BYTE_TAB;
              CH_U: begin
                mode    = MODE_HEX;
                hex_cnt = '0;
                cp      = '0;
              end
              default: fail(ERR_ESCAPE);
            endcase
            // still in escape mode means a single-byte escape was taken
            if (mode == MODE_ESC) begin
              mode = MODE_STR;
              add(r, KIND_DATA, ERR_NONE);
            end
          end
        end
        default: begin
          d = nibble_of(b);
          if (eof) fail(ERR_EOF);
          else if (!d[4]) fail(ERR_HEX);
          else begin
            v = {cp[11:0], d[3:0]};
            if (hex_cnt == 2'd3) begin
              mode    = MODE_STR;
              hex_cnt = '0;
              cp      = '0;
              // UTF-8: 1, 2 or 3 bytes by code point range
              if (v <= CP_MAX_1B) add(v[7:0], KIND_DATA, ERR_NONE);
              else if (v <= CP_MAX_2B) begin
                add(UTF8_LEAD2 | {3'b0, v[10:6]}, KIND_DATA, ERR_NONE);
                add(UTF8_CONT | {2'b0, v[5:0]}, KIND_DATA, ERR_NONE);
              end else begin
                add(UTF8_LEAD3 | {4'b0, v[15:12]}, KIND_DATA, ERR_NONE);
                add(UTF8_CONT | {2'b0, v[11:6]}, KIND_DATA, ERR_NONE);
                add(UTF8_CONT | {2'b0, v[5:0]}, KIND_DATA, ERR_NONE);
              end
            end else begin
              cp      = v;
              hex_cnt = hex_cnt + 2'd1;
            end
          end
        end
      endcase
      if (decoded_q.size() > n0) decoded_q[decoded_q.size() - 1].last = 1'b1;
    endfunction

    function void note_bad(string msg);
      bad++;
      if (bad <= 10) $display("mismatch: %s", msg);
    endfunction

    // Compare one result transfer with the oldest pending one
    function void match_decoded(logic [7:0] b, logic [1:0] k, logic [2:0] e, logic l);
      decoded_t want;
      n_checked++;
      if (k == KIND_END) n_ends++;
      if (k == KIND_ERR) n_errs++;
      if (decoded_q.size() == 0) begin
        note_bad($sformatf("unexpected result byte %02h kind %0d err %0d last %0d",
                           b, k, e, l));
        return;
      end
      want = decoded_q.pop_front();
      if (want.data !== b || want.kind !== k || want.err !== e || want.last !== l)
        note_bad($sformatf("got byte %02h kind %0d err %0d last %0d, want %02h %0d %0d %0d",
                           b, k, e, l, want.data, want.kind, want.err, want.last));
    endfunction
  endclass

  localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                             CH_F, CH_N, CH_R, CH_T};
  localparam logic [15:0] CP_CORNERS [8] = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff,
                                            16'h0800, 16'hd800, 16'hdfff, 16'hffff};
  localparam int PHASE_IN_IDLE  [4] = '{0, 66, 0, 37};
  localparam int PHASE_OUT_STALL[4] = '{0, 0, 66, 37};

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_stall_pct;
  int   n_sent;

  unescape_tracker sb = new();

  jsd_in_if  in_ch();
  jsd_out_if out_ch();

  json_string_literal_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Monitors and receiver backpressure
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.take_text_byte(in_ch.in_byte, in_ch.in_eof);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.match_decoded(out_ch.out_byte, out_ch.out_kind, out_ch.err_code, out_ch.last);
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_0 + 8'(n);
    return (($urandom_range(1) != 0) ? CH_UA : CH_LA) + 8'(n) - 8'd10;
  endfunction

  // One input transfer, with optional sender gap in front
  task automatic send_item(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_eof  <= e;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  // End of data; the byte lane carries garbage
  task automatic send_eof();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_hex_escape(input logic [15:0] v);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) send_item(hex_char(v[i*4 +: 4]), 1'b0);
  endtask

  // Mostly well-formed strings, some idle noise and broken tails
  task automatic random_string();
    int          len;
    int          pick;
    int          k;
    logic [7:0]  b;
    logic [4:0]  nb;
    logic [15:0] v;
    pick = $urandom_range(99);
    if (pick < 6) begin
      do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
      send_item(b, 1'b0);
    end else if (pick < 9) send_eof();
    send_item(CH_QUOTE, 1'b0);
    len = $urandom_range(6);
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
        send_item(b, 1'b0);
      end else if (pick < 72) begin
        send_item(CH_BSLASH, 1'b0);
        send_item(ESC_LETTERS[$urandom_range(7)], 1'b0);
      end else if (pick < 92) begin
        case ($urandom_range(4))
          0:       v = 16'($urandom_range(16'h007f));
          1:       v = 16'($urandom_range(16'h07ff, 16'h0080));
          2:       v = 16'($urandom_range(16'hffff, 16'h0800));
          3:       v = CP_CORNERS[$urandom_range(7)];
          default: v = 16'($urandom);
        endcase
        send_hex_escape(v);
      end else begin
        // broken tail: the block drops back to idle
        case ($urandom_range(4))
          0: send_eof();
          1: begin
            send_item(CH_BSLASH, 1'b0);
            send_eof();
          end
          2: begin
            send_item(CH_BSLASH, 1'b0);
            do b = 8'($urandom_range(255));
            while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R,
                             CH_T, CH_U});
            send_item(b, 1'b0);
          end
          default: begin
            send_item(CH_BSLASH, 1'b0);
            send_item(CH_U, 1'b0);
            k = $urandom_range(3);
            repeat (k) send_item(hex_char(4'($urandom_range(15))), 1'b0);
            if ($urandom_range(1) != 0) send_eof();
            else begin
              do begin
                b  = 8'($urandom_range(255));
                nb = sb.nibble_of(b);
              end while (nb[4]);
              send_item(b, 1'b0);
            end
          end
        endcase
        return;
      end
    end
    send_item(CH_QUOTE, 1'b0);
  endtask

  // Hold the sender off until every pending result has been seen
  task automatic drain_results();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    // let the monitor take the last input transfer first
    @(posedge clk);
    while (sb.decoded_q.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Stimulus and end of run
  initial begin
    int target;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_eof  = 1'b0;
    out_ch.ready  = 1'b0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    n_sent        = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: stray byte and end of data while idle
    send_item(8'h61, 1'b0);
    send_eof();
    // byte extremes, then an unknown escape letter
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(8'h71, 1'b0);
    // code point zero and the top code point
    send_item(CH_QUOTE, 1'b0);
    send_hex_escape(16'h0000);
    send_hex_escape(16'hffff);
    // non-hex digit after \u
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_U, 1'b0);
    send_item(8'h67, 1'b0);
    // end of data inside a string
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_N, 1'b0);
    send_eof();
    // empty string
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    drain_results();

    // Random phases with different handshake pressure
    for (int p = 0; p < 4; p++) begin
      in_idle_pct   = PHASE_IN_IDLE[p];
      out_stall_pct = PHASE_OUT_STALL[p];
      target        = n_sent + 70;
      while (n_sent < target) random_string();
      drain_results();
    end

    out_stall_pct = 0;
    drain_results();
    repeat (8) @(posedge clk);
    if (sb.decoded_q.size() != 0)
      sb.note_bad($sformatf("%0d results never arrived", sb.decoded_q.size()));

    $display("run covered %0d input transfers and %0d results (%0d string ends, %0d errors)",
             n_sent, sb.n_checked, sb.n_ends, sb.n_errs);
    $display("four handshake phases from free-running to both sides throttled; %0d mismatches",
             sb.bad);
    if (sb.bad == 0) begin
      $display("[json_string_literal_decoder] OK");
    end else begin
      $display("[json_string_literal_decoder] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500000;
    $display("[json_string_literal_decoder] ERROR");
    $finish;
  end

endmodule
